>>> design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define KSA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KSA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KSA_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/ksa_pkg.sv
package ksa_pkg;

   localparam int COORD_BITS     = 12;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int WEIGHT_BITS    = 8;
   localparam int LAT_FRAC       = 16;
   localparam int DIV_STAGES     = 8;
   localparam int DIV_STEP       = 4;

   localparam logic signed [20:0] IR3_Q20 = 21'sd605396;
   localparam logic signed [21:0] R3_Q20  = 22'sd1816187;

   localparam logic [12:0] FRAME_LIMIT = 13'd4096;

   // register map, index is paddr[4:2]
   localparam logic [2:0] REG_CENTER_X     = 3'd0;
   localparam logic [2:0] REG_CENTER_Y     = 3'd1;
   localparam logic [2:0] REG_CELL_SIZE    = 3'd2;
   localparam logic [2:0] REG_COS_ANGLE    = 3'd3;
   localparam logic [2:0] REG_SIN_ANGLE    = 3'd4;
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;

   localparam logic [1:0] FOLD_A = 2'd0;
   localparam logic [1:0] FOLD_B = 2'd1;
   localparam logic [1:0] FOLD_C = 2'd2;

   // mathematical mod 3 of a 17 bit two's complement value
   function automatic logic [1:0] mod3_s17(input logic [16:0] x);
      logic [5:0] acc;
      acc = 6'd0;
      for (int i = 0; i < 17; i++) begin
         if (i % 2 == 0) acc = acc + {5'd0, x[i]};
         else acc = acc + {4'd0, x[i], 1'b0};
      end
      // -2^16 is 2 mod 3
      acc = acc + {5'd0, x[16]};
      for (int k = 0; k < 4; k++) begin
         acc = {4'd0, acc[1:0]} + {2'd0, acc[5:2]};
      end
      return (acc[1:0] == 2'd3) ? 2'd0 : acc[1:0];
   endfunction

endpackage

>>> design/kaleidoscope_source_address_top.sv
// channel  | direction | ports
// req      | in        | req_valid, req_stall, req_pixel_x, req_pixel_y
// rsp      | out       | rsp_valid, rsp_stall, rsp_source_col/row, rsp_weight_x/y,
//          |           | rsp_inside_res
// csr      | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// one item per cycle while no result is held on rsp
// the lattice divide by cell_size is 8 stages of 4 restoring steps each
// synchronous reset clears the valid bits and loads the register defaults
// a held result on rsp stalls every stage at once, so req_stall follows it
`include "assert_macros.svh"

module kaleidoscope_source_address_top
   import ksa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_source_col,
   output logic [11:0] rsp_source_row,
   output logic [7:0]  rsp_weight_x,
   output logic [7:0]  rsp_weight_y,
   output logic        rsp_inside_res,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration registers
   logic [11:0] center_x_ff, center_y_ff;
   logic [8:0]  cell_size_ff;
   logic [15:0] cos_ff, sin_ff;
   logic [12:0] frame_width_ff, frame_height_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= 12'd100;
         center_y_ff     <= 12'd100;
         cell_size_ff    <= 9'd100;
         cos_ff          <= 16'd16384;
         sin_ff          <= 16'd0;
         frame_width_ff  <= 13'd1920;
         frame_height_ff <= 13'd1080;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_CENTER_X:     center_x_ff     <= pwdata[11:0];
            REG_CENTER_Y:     center_y_ff     <= pwdata[11:0];
            REG_CELL_SIZE:    cell_size_ff    <= pwdata[8:0];
            REG_COS_ANGLE:    cos_ff          <= pwdata[15:0];
            REG_SIN_ANGLE:    sin_ff          <= pwdata[15:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[12:0];
            REG_FRAME_HEIGHT: frame_height_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_CENTER_X:     prdata = {20'd0, center_x_ff};
         REG_CENTER_Y:     prdata = {20'd0, center_y_ff};
         REG_CELL_SIZE:    prdata = {23'd0, cell_size_ff};
         REG_COS_ANGLE:    prdata = {16'd0, cos_ff};
         REG_SIN_ANGLE:    prdata = {16'd0, sin_ff};
         REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_ff};
         REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_ff};
         default:          prdata = 32'd0;
      endcase
   end

   logic signed [15:0] c_s, s_s;
   logic [8:0]  csz;
   logic [12:0] fw, fh;
   assign c_s = signed'(cos_ff);
   assign s_s = signed'(sin_ff);
   assign csz = (cell_size_ff == 9'd0) ? 9'd1 : cell_size_ff;
   assign fw  = (frame_width_ff > FRAME_LIMIT) ? FRAME_LIMIT : frame_width_ff;
   assign fh  = (frame_height_ff > FRAME_LIMIT) ? FRAME_LIMIT : frame_height_ff;

   // back rotation coefficients, rounded half up, follow the trig registers
   logic signed [37:0] r3s, r3c;
   logic signed [39:0] kx_full, ky_full;
   logic signed [17:0] kx_ff, ky_ff, kx_in, ky_in;
   always_comb begin
      r3s     = R3_Q20 * s_s;
      r3c     = R3_Q20 * c_s;
      kx_full = (40'(c_s) <<< 20) - 40'(r3s) + 40'sd1048576;
      ky_full = (40'(s_s) <<< 20) + 40'(r3c) + 40'sd1048576;
      kx_in   = kx_full[38:21];
      ky_in   = ky_full[38:21];
   end
   always_ff @(posedge clock) begin
      kx_ff <= kx_in;
      ky_ff <= ky_in;
   end

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage 1: offsets and rotation products
   logic v1_ff;
   logic signed [12:0] dx, dy;
   logic signed [28:0] cdx_ff, sdy_ff, cdy_ff, sdx_ff;
   assign dx = signed'({1'b0, req_pixel_x}) - signed'({1'b0, center_x_ff});
   assign dy = signed'({1'b0, req_pixel_y}) - signed'({1'b0, center_y_ff});
   always_ff @(posedge clock) begin
      if (adv) begin
         cdx_ff <= c_s * dx;
         sdy_ff <= s_s * dy;
         cdy_ff <= c_s * dy;
         sdx_ff <= s_s * dx;
      end
   end

   // stage 2: rotated point u, v
   logic v2_ff;
   logic signed [29:0] u2_ff, v2d_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         u2_ff  <= 30'(cdx_ff) + 30'(sdy_ff);
         v2d_ff <= 30'(cdy_ff) - 30'(sdx_ff);
      end
   end

   // stage 3: v scaled by 1/sqrt3
   logic v3_ff;
   logic signed [29:0] u3_ff;
   logic signed [50:0] pv3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         u3_ff  <= u2_ff;
         pv3_ff <= v2d_ff * IR3_Q20;
      end
   end

   // stage 4: dividends pre-shifted, sign folded as ones' complement for floor
   logic v4_ff;
   logic signed [50:0] nw_full;
   logic signed [31:0] nw, nz;
   logic [31:0] magw_ff, magz_ff;
   logic negw_ff, negz_ff;
   assign nw_full = (51'(u3_ff) <<< 20) - pv3_ff;
   assign nw      = nw_full[49:18];
   assign nz      = pv3_ff[48:17];
   always_ff @(posedge clock) begin
      if (adv) begin
         negw_ff <= nw[31];
         negz_ff <= nz[31];
         magw_ff <= nw[31] ? ~nw : nw;
         magz_ff <= nz[31] ? ~nz : nz;
      end
   end

   // divider: lane 0 is w, lane 1 is z
   logic        dv_ff  [DIV_STAGES];
   logic        dng_ff [DIV_STAGES][2];
   logic [8:0]  drem_ff[DIV_STAGES][2];
   logic [31:0] dnum_ff[DIV_STAGES][2];
   logic [31:0] dq_ff  [DIV_STAGES][2];
   logic [8:0]  drem_in[DIV_STAGES][2];
   logic [31:0] dnum_in[DIV_STAGES][2];
   logic [31:0] dq_in  [DIV_STAGES][2];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      for (genvar l = 0; l < 2; l++) begin : g_lane
         always_comb begin
            logic [8:0]  r;
            logic [31:0] n;
            logic [31:0] q;
            logic [9:0]  t;
            if (k == 0) begin
               r = 9'd0;
               n = (l == 0) ? magw_ff : magz_ff;
               q = 32'd0;
            end else begin
               r = drem_ff[k-1][l];
               n = dnum_ff[k-1][l];
               q = dq_ff[k-1][l];
            end
            for (int j = 0; j < DIV_STEP; j++) begin
               t = {r, n[31]};
               n = {n[30:0], 1'b0};
               if (t >= {1'b0, csz}) begin
                  t = t - {1'b0, csz};
                  q = {q[30:0], 1'b1};
               end else begin
                  q = {q[30:0], 1'b0};
               end
               r = t[8:0];
            end
            drem_in[k][l] = r;
            dnum_in[k][l] = n;
            dq_in[k][l]   = q;
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               drem_ff[k][l] <= drem_in[k][l];
               dnum_ff[k][l] <= dnum_in[k][l];
               dq_ff[k][l]   <= dq_in[k][l];
               if (k == 0) dng_ff[k][l] <= (l == 0) ? negw_ff : negz_ff;
               else        dng_ff[k][l] <= dng_ff[k-1][l];
            end
         end
      end
   end

   // fold stage 1: cell parts, fold select and fractions
   logic [31:0] wq, zq;
   logic [16:0] cdiff;
   logic        vf1_ff;
   logic [1:0]  sel_ff;
   logic [15:0] a_ff, b_ff;
   logic [16:0] sum;
   logic        low_ff;
   assign wq    = dng_ff[DIV_STAGES-1][0] ? ~dq_ff[DIV_STAGES-1][0] : dq_ff[DIV_STAGES-1][0];
   assign zq    = dng_ff[DIV_STAGES-1][1] ? ~dq_ff[DIV_STAGES-1][1] : dq_ff[DIV_STAGES-1][1];
   assign cdiff = {wq[31], wq[31:16]} - {zq[31], zq[31:16]};
   assign sum   = {1'b0, wq[15:0]} + {1'b0, zq[15:0]};
   always_ff @(posedge clock) begin
      if (adv) begin
         sel_ff <= mod3_s17(cdiff);
         a_ff   <= wq[15:0];
         b_ff   <= zq[15:0];
         low_ff <= (sum <= 17'h10000);
      end
   end

   // fold stage 2: mirror into the base triangle
   localparam logic [16:0] ONE = 17'h10000;
   logic        vf2_ff;
   logic [16:0] fa_in, fb_in, fa_ff, fb_ff, ab, mid, oma, omb;
   always_comb begin
      ab  = {1'b0, a_ff} + {1'b0, b_ff};
      mid = low_ff ? (ONE - ab) : (ab - ONE);
      oma = ONE - {1'b0, a_ff};
      omb = ONE - {1'b0, b_ff};
      case (sel_ff)
         FOLD_A: begin
            fa_in = low_ff ? {1'b0, a_ff} : omb;
            fb_in = low_ff ? {1'b0, b_ff} : oma;
         end
         FOLD_B: begin
            fa_in = mid;
            fb_in = low_ff ? {1'b0, a_ff} : omb;
         end
         FOLD_C: begin
            fa_in = low_ff ? {1'b0, b_ff} : oma;
            fb_in = mid;
         end
         default: begin
            fa_in = 17'd0;
            fb_in = 17'd0;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         fa_ff <= fa_in;
         fb_ff <= fb_in;
      end
   end

   // scale by cell size
   logic vf3_ff;
   logic [25:0] bw_ff, bz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         bw_ff <= fa_ff * csz;
         bz_ff <= fb_ff * csz;
      end
   end

   // back rotation products
   logic vf4_ff;
   logic signed [26:0] bws, bzs;
   logic signed [42:0] cbw_ff, sbw_ff;
   logic signed [44:0] kbz_ff, lbz_ff;
   assign bws = signed'({1'b0, bw_ff});
   assign bzs = signed'({1'b0, bz_ff});
   always_ff @(posedge clock) begin
      if (adv) begin
         cbw_ff <= c_s * bws;
         sbw_ff <= s_s * bws;
         kbz_ff <= kx_ff * bzs;
         lbz_ff <= ky_ff * bzs;
      end
   end

   // source position in Q.16
   logic vf5_ff;
   logic signed [45:0] xsum, ysum;
   logic signed [33:0] xq_ff, yq_ff;
   assign xsum = 46'(cbw_ff) + 46'(kbz_ff);
   assign ysum = 46'(sbw_ff) + 46'(lbz_ff);
   always_ff @(posedge clock) begin
      if (adv) begin
         xq_ff <= 34'(signed'(xsum[45:14])) + signed'({6'd0, center_x_ff, 16'd0});
         yq_ff <= 34'(signed'(ysum[45:14])) + signed'({6'd0, center_y_ff, 16'd0});
      end
   end

   // range check and output register
   logic [17:0] col, row;
   logic        in_frame;
   logic        rsp_valid_ff;
   logic [11:0] col_ff, row_ff;
   logic [7:0]  wx_ff, wy_ff;
   logic        inside_ff;
   assign col      = xq_ff[33:16];
   assign row      = yq_ff[33:16];
   assign in_frame = !col[17] && (col[16:0] < {4'd0, fw})
                  && !row[17] && (row[16:0] < {4'd0, fh});
   always_ff @(posedge clock) begin
      if (adv) begin
         col_ff    <= in_frame ? col[11:0] : 12'd0;
         row_ff    <= in_frame ? row[11:0] : 12'd0;
         wx_ff     <= in_frame ? xq_ff[15:8] : 8'd0;
         wy_ff     <= in_frame ? yq_ff[15:8] : 8'd0;
         inside_ff <= in_frame;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         vf1_ff       <= 1'b0;
         vf2_ff       <= 1'b0;
         vf3_ff       <= 1'b0;
         vf4_ff       <= 1'b0;
         vf5_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_STAGES; k++) dv_ff[k] <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         dv_ff[0] <= v4_ff;
         for (int k = 1; k < DIV_STAGES; k++) dv_ff[k] <= dv_ff[k-1];
         vf1_ff       <= dv_ff[DIV_STAGES-1];
         vf2_ff       <= vf1_ff;
         vf3_ff       <= vf2_ff;
         vf4_ff       <= vf3_ff;
         vf5_ff       <= vf4_ff;
         rsp_valid_ff <= vf5_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_source_col = col_ff;
   assign rsp_source_row = row_ff;
   assign rsp_weight_x   = wx_ff;
   assign rsp_weight_y   = wy_ff;
   assign rsp_inside_res = inside_ff;

   `KSA_ASSERT_IMP(a_outside_zero, clock, reset, rsp_valid && !rsp_inside_res,
      (rsp_source_col == 12'd0) && (rsp_source_row == 12'd0) && (rsp_weight_x == 8'd0)
      && (rsp_weight_y == 8'd0), "outside result carries nonzero fields")
   `KSA_ASSERT_IMP(a_inside_range, clock, reset, rsp_valid && rsp_inside_res,
      ({1'b0, rsp_source_col} < fw) && ({1'b0, rsp_source_row} < fh),
      "inside result beyond frame")
   `KSA_ASSERT_NXT(a_accept_enters, clock, reset, req_valid && !req_stall, v1_ff,
      "accepted item did not enter the pipeline")
   `KSA_ASSERT_NXT(a_stall_holds, clock, reset, req_stall, rsp_valid,
      "pipeline stalled without a waiting result")

endmodule

>>> verif/kaleidoscope_source_address_top_tb.sv
`timescale 1ns / 1ps

module kaleidoscope_source_address_top_tb;
   import ksa_pkg::*;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
      logic [7:0]  wx;
      logic [7:0]  wy;
      logic        in_frame;
   } source_addr_type;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [11:0] req_pixel_x = '0;
   logic [11:0] req_pixel_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_source_col;
   logic [11:0] rsp_source_row;
   logic [7:0]  rsp_weight_x;
   logic [7:0]  rsp_weight_y;
   logic        rsp_inside_res;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   kaleidoscope_source_address_top dut (.*);

   // shadow copy of the registers
   logic [11:0] sh_center_x = 12'd100;
   logic [11:0] sh_center_y = 12'd100;
   logic [8:0]  sh_cell = 9'd100;
   logic [15:0] sh_cos = 16'd16384;
   logic [15:0] sh_sin = 16'd0;
   logic [12:0] sh_width = 13'd1920;
   logic [12:0] sh_height = 13'd1080;

   pixel_type       pixel_queue[$];
   source_addr_type expected_addrs[$];
   bit              req_taken = 0;
   int              send_idle_pct = 6;
   int              recv_idle_pct = 48;
   int              rsp_hold_left = 0;
   int              mismatches = 0;
   int              quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) < 0) q--;
      return q;
   endfunction

   function automatic source_addr_type map_pixel(logic [11:0] px, logic [11:0] py);
      longint one, ks, dx, dy, c, s, cs, u, v, dv, wq, zq, cw, cz, a, b, sel;
      longint fa, fb, kx, ky, xq, yq, col, row, fw, fh;
      bit     low;
      source_addr_type r;
      one = 64'sd1 <<< LAT_FRAC;
      ks  = 64'sd1 <<< 20;
      dx  = longint'(px) - longint'(sh_center_x);
      dy  = longint'(py) - longint'(sh_center_y);
      c   = longint'($signed(sh_cos));
      s   = longint'($signed(sh_sin));
      cs  = (sh_cell == 0) ? 1 : longint'(sh_cell);
      u   = c * dx + s * dy;
      v   = c * dy - s * dx;
      dv  = cs * (64'sd1 <<< (TRIG_FRAC_BITS + 20 - LAT_FRAC));
      wq  = floor_div(u * ks - v * 605396, dv);
      zq  = floor_div(2 * v * 605396, dv);
      cw  = floor_div(wq, one);
      cz  = floor_div(zq, one);
      a   = wq - cw * one;
      b   = zq - cz * one;
      sel = ((cw % 3 - cz % 3) % 3 + 3) % 3;
      low = (a + b) <= one;
      if (sel == FOLD_A) begin
         fa = low ? a : one - b;
         fb = low ? b : one - a;
      end else if (sel == FOLD_B) begin
         fa = low ? one - a - b : a + b - one;
         fb = low ? a : one - b;
      end else begin
         fa = low ? b : one - a;
         fb = low ? one - a - b : a + b - one;
      end
      kx  = floor_div(c * ks - 1816187 * s + ks, 2 * ks);
      ky  = floor_div(s * ks + 1816187 * c + ks, 2 * ks);
      xq  = floor_div(c * fa * cs + kx * fb * cs, 64'sd1 <<< TRIG_FRAC_BITS)
            + longint'(sh_center_x) * one;
      yq  = floor_div(s * fa * cs + ky * fb * cs, 64'sd1 <<< TRIG_FRAC_BITS)
            + longint'(sh_center_y) * one;
      col = floor_div(xq, one);
      row = floor_div(yq, one);
      fw  = (sh_width > FRAME_LIMIT) ? 4096 : longint'(sh_width);
      fh  = (sh_height > FRAME_LIMIT) ? 4096 : longint'(sh_height);
      r = '0;
      if (col >= 0 && col < fw && row >= 0 && row < fh) begin
         r.col      = col[11:0];
         r.row      = row[11:0];
         r.wx       = 8'((xq - col * one) >>> (LAT_FRAC - WEIGHT_BITS));
         r.wy       = 8'((yq - row * one) >>> (LAT_FRAC - WEIGHT_BITS));
         r.in_frame = 1'b1;
      end
      return r;
   endfunction

   // input driver
   always @(negedge clock) begin
      pixel_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 0;
         if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            p = pixel_queue.pop_front();
            req_valid   <= 1'b1;
            req_pixel_x <= p.x;
            req_pixel_y <= p.y;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off when asked
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // accept side and result checker
   always @(posedge clock) begin
      source_addr_type want, got;
      if (!reset && req_valid && !req_stall) begin
         expected_addrs.push_back(map_pixel(req_pixel_x, req_pixel_y));
         req_taken = 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_source_col, rsp_source_row, rsp_weight_x, rsp_weight_y, rsp_inside_res};
         if (expected_addrs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %p", got);
         end else begin
            want = expected_addrs.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected col %0d row %0d wx %0d wy %0d in %0d,",
                           want.col, want.row, want.wx, want.wy, want.in_frame,
                           " got col %0d row %0d wx %0d wy %0d in %0d",
                           got.col, got.row, got.wx, got.wy, got.in_frame);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = {idx, 2'b00}; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
      case (idx)
         REG_CENTER_X:     sh_center_x = val[11:0];
         REG_CENTER_Y:     sh_center_y = val[11:0];
         REG_CELL_SIZE:    sh_cell = val[8:0];
         REG_COS_ANGLE:    sh_cos = val[15:0];
         REG_SIN_ANGLE:    sh_sin = val[15:0];
         REG_FRAME_WIDTH:  sh_width = val[12:0];
         REG_FRAME_HEIGHT: sh_height = val[12:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [11:0] cx, logic [11:0] cy, logic [8:0] cell_len,
                            logic [15:0] cosv, logic [15:0] sinv,
                            logic [12:0] fw, logic [12:0] fh);
      csr_write(REG_CENTER_X, {20'd0, cx});
      csr_write(REG_CENTER_Y, {20'd0, cy});
      csr_write(REG_CELL_SIZE, {23'd0, cell_len});
      csr_write(REG_COS_ANGLE, {16'd0, cosv});
      csr_write(REG_SIN_ANGLE, {16'd0, sinv});
      csr_write(REG_FRAME_WIDTH, {19'd0, fw});
      csr_write(REG_FRAME_HEIGHT, {19'd0, fh});
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pixel_queue.size() > 0 || req_valid || expected_addrs.size() > 0);
      repeat (25) @(posedge clock);
   endtask

   task automatic add_pixel(logic [11:0] x, logic [11:0] y);
      pixel_type p;
      p.x = x;
      p.y = y;
      pixel_queue.push_back(p);
   endtask

   initial begin
      real         th;
      logic [15:0] cv, sv;
      logic [12:0] fw, fh;
      logic [11:0] cx, cy;
      logic [8:0]  cell_len;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes at reset settings
      add_pixel(12'd0, 12'd0);
      add_pixel(12'd4095, 12'd4095);
      add_pixel(12'd0, 12'd4095);
      add_pixel(12'd4095, 12'd0);
      add_pixel(12'd100, 12'd100);
      add_pixel(12'd150, 12'd120);
      add_pixel(12'd2730, 12'd1365);
      drain();

      // zero cell size, zero frame, oversized frame, odd trig patterns
      write_all(12'd0, 12'd4095, 9'd0, 16'h8000, 16'h7fff, 13'd8191, 13'd0);
      add_pixel(12'd0, 12'd0);
      add_pixel(12'd4095, 12'd4095);
      add_pixel(12'd5, 12'd4090);
      drain();
      write_all(12'd4095, 12'd0, 9'd511, 16'hc000, 16'h4000, 13'd4096, 13'd8191);
      add_pixel(12'd4095, 12'd0);
      add_pixel(12'd0, 12'd4095);
      add_pixel(12'd3000, 12'd700);
      add_pixel(12'd4000, 12'd10);
      drain();
      write_all(12'd2048, 12'd2048, 9'd1, 16'd16384, 16'd0, 13'd1, 13'd4096);
      add_pixel(12'd2048, 12'd2048);
      add_pixel(12'd2049, 12'd2047);
      add_pixel(12'd0, 12'd2048);
      drain();
      write_all(12'd300, 12'd200, 9'd500, 16'd0, 16'hc000, 13'd4096, 13'd4096);
      add_pixel(12'd0, 12'd0);
      add_pixel(12'd4095, 12'd4095);
      add_pixel(12'd800, 12'd900);
      drain();

      for (int ph = 0; ph < 17; ph++) begin
         if (ph < 6) begin
            send_idle_pct = 6; recv_idle_pct = 48;
         end else if (ph < 12) begin
            send_idle_pct = 48; recv_idle_pct = 6;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         th = $urandom_range(0, 62831) / 10000.0;
         cv = 16'($rtoi(16384.0 * $cos(th)));
         sv = 16'($rtoi(16384.0 * $sin(th)));
         if (ph % 5 == 4) begin
            cv = 16'($urandom);
            sv = 16'($urandom);
         end
         fw   = (ph % 4 == 3) ? 13'($urandom) : 13'($urandom_range(1, 4096));
         fh   = (ph % 4 == 2) ? 13'($urandom) : 13'($urandom_range(1, 4096));
         cx   = 12'($urandom);
         cy   = 12'($urandom);
         cell_len = (ph % 6 == 5) ? 9'($urandom) : 9'($urandom_range(1, 500));
         if (ph % 2 == 0) begin
            // keep the centre inside the frame so most items land inside
            cx = 12'($urandom_range(0, (fw > 1 && fw <= 4096) ? fw - 1 : 0));
            cy = 12'($urandom_range(0, (fh > 1 && fh <= 4096) ? fh - 1 : 0));
         end
         write_all(cx, cy, cell_len, cv, sv, fw, fh);
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(3) == 0) add_pixel(12'($urandom), 12'($urandom));
            else add_pixel(12'($urandom_range(0, (fw > 0 && fw <= 4096) ? fw - 1 : 4095)),
                           12'($urandom_range(0, (fh > 0 && fh <= 4096) ? fh - 1 : 4095)));
         end
         // long receiver hold-off so the pipeline fills and stalls its input
         if (ph == 13) begin
            @(negedge clock);
            rsp_hold_left = 80;
         end
         drain();
      end

      if (mismatches == 0 && expected_addrs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
